// ----- sv/sae_pkg.sv -----
`default_nettype none
package sae_pkg;

    localparam int MAX_SYMBOLS   = 4096;
    localparam int ALPHABET_SIZE = 26;
    localparam int NSTATES       = 2 * MAX_SYMBOLS;
    localparam int STATE_W       = $clog2(NSTATES);
    localparam int SYM_W         = 5;
    localparam int TAKEN_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int TRANS_DEPTH   = NSTATES * ALPHABET_SIZE;
    localparam int TRANS_AW      = $clog2(TRANS_DEPTH);
    localparam int CNT_W         = $clog2(ALPHABET_SIZE + 1);

    localparam logic [STATE_W-1:0] ROOT_STATE = STATE_W'(1);
    localparam logic [STATE_W-1:0] NO_STATE   = STATE_W'(0);

    // controller states, also the command that selects the datapath operation
    typedef enum logic [8:0] {
        OP_CLEAR  = 9'b000000001,
        OP_IDLE   = 9'b000000010,
        OP_W1_RD  = 9'b000000100,
        OP_W1_CHK = 9'b000001000,
        OP_Q_CHK  = 9'b000010000,
        OP_COPY   = 9'b000100000,
        OP_W2_RD  = 9'b001000000,
        OP_W2_CHK = 9'b010000000,
        OP_FIN    = 9'b100000000
    } op_t;

    typedef struct packed {
        op_t  op;
        logic accept;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic special;
        logic p_zero;
        logic edge_zero;
        logic len_match;
        logic copy_done;
        logic edge_is_q;
        logic out_free;
    } status_t;

    // row-major transition address: state * alphabet + symbol
    function automatic logic [TRANS_AW-1:0] trans_addr(
        input logic [STATE_W-1:0] s,
        input logic [SYM_W-1:0]   c
    );
        trans_addr = TRANS_AW'(s) * TRANS_AW'(ALPHABET_SIZE) + TRANS_AW'(c);
    endfunction

endpackage
`default_nettype wire

// ----- sv/sae_ram.sv -----
`default_nettype none
module sae_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- sv/sae_ctrl.sv -----
`default_nettype none
module sae_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire sae_pkg::status_t status,
    output sae_pkg::cmd_t         cmd
);

    sae_pkg::op_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sae_pkg::OP_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sae_pkg::OP_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = sae_pkg::OP_IDLE;
                end
            end
            sae_pkg::OP_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.special ? sae_pkg::OP_FIN : sae_pkg::OP_W1_RD;
                end
            end
            sae_pkg::OP_W1_RD:
            begin
                state_next = status.p_zero ? sae_pkg::OP_FIN : sae_pkg::OP_W1_CHK;
            end
            sae_pkg::OP_W1_CHK:
            begin
                state_next = status.edge_zero ? sae_pkg::OP_W1_RD : sae_pkg::OP_Q_CHK;
            end
            sae_pkg::OP_Q_CHK:
            begin
                state_next = status.len_match ? sae_pkg::OP_FIN : sae_pkg::OP_COPY;
            end
            sae_pkg::OP_COPY:
            begin
                if (status.copy_done)
                begin
                    state_next = sae_pkg::OP_W2_RD;
                end
            end
            sae_pkg::OP_W2_RD:
            begin
                state_next = status.p_zero ? sae_pkg::OP_FIN : sae_pkg::OP_W2_CHK;
            end
            sae_pkg::OP_W2_CHK:
            begin
                state_next = status.edge_is_q ? sae_pkg::OP_W2_RD : sae_pkg::OP_FIN;
            end
            sae_pkg::OP_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = sae_pkg::OP_IDLE;
                end
            end
            default:
            begin
                state_next = sae_pkg::OP_CLEAR;
            end
        endcase
    end

    assign in_stall   = (state_reg != sae_pkg::OP_IDLE);
    assign cmd.op     = state_reg;
    assign cmd.accept = in_valid && (state_reg == sae_pkg::OP_IDLE);

endmodule
`default_nettype wire

// ----- sv/sae_dp.sv -----
`default_nettype none
module sae_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sae_pkg::cmd_t                 cmd,
    output sae_pkg::status_t                   status,
    input  wire logic [sae_pkg::SYM_W-1:0]     symbol,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [sae_pkg::STATE_W-1:0]   new_state,
    output logic      [sae_pkg::STATE_W-1:0]   suffix_link,
    output logic      [sae_pkg::STATE_W-1:0]   prefix_length,
    output logic      [sae_pkg::STATE_W-1:0]   state_count,
    output logic                               cloned,
    output logic                               overflow
);

    localparam int SW = sae_pkg::STATE_W;
    localparam int AW = sae_pkg::TRANS_AW;

    // automaton bookkeeping
    logic [SW-1:0]               last_reg, last_next;
    logic [SW-1:0]               last_link_reg, last_link_next;
    logic [SW-1:0]               last_len_reg, last_len_next;
    logic [SW-1:0]               used_reg, used_next;
    logic [sae_pkg::TAKEN_W-1:0] taken_reg, taken_next;
    logic                        clone_reg, clone_next;
    logic                        ovf_reg, ovf_next;
    logic [AW-1:0]               clr_reg, clr_next;
    logic [sae_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    // walk working registers
    logic [SW-1:0]               p_reg, p_next;
    logic [SW-1:0]               q_reg, q_next;
    logic [SW-1:0]               np_reg, np_next;
    logic [SW-1:0]               nq_reg, nq_next;
    logic [SW-1:0]               want_reg, want_next;
    logic [sae_pkg::SYM_W-1:0]   c_reg, c_next;

    // result register
    logic          out_valid_reg, out_valid_next;
    logic [SW-1:0] o_state_reg, o_state_next;
    logic [SW-1:0] o_link_reg, o_link_next;
    logic [SW-1:0] o_len_reg, o_len_next;
    logic [SW-1:0] o_count_reg, o_count_next;
    logic          o_clone_reg, o_clone_next;
    logic          o_ovf_reg, o_ovf_next;

    // memory ports
    logic                      tr_we;
    logic [AW-1:0]             tr_waddr, tr_raddr;
    logic [SW-1:0]             tr_wdata, tr_rdata;
    logic [SW-1:0]             tr_ws, tr_rs;
    logic [sae_pkg::SYM_W-1:0] tr_wc, tr_rc;
    logic                      len_we, link_we;
    logic [SW-1:0]             len_waddr, len_wdata, len_raddr, len_rdata;
    logic [SW-1:0]             link_waddr, link_wdata, link_raddr, link_rdata;

    logic taken_full, bad_sym, out_free;

    assign taken_full = (taken_reg >= sae_pkg::TAKEN_W'(sae_pkg::MAX_SYMBOLS));
    assign bad_sym    = (symbol >= sae_pkg::SYM_W'(sae_pkg::ALPHABET_SIZE));
    assign out_free   = !out_valid_reg || !out_stall;

    assign status.clear_done = (clr_reg == AW'(sae_pkg::TRANS_DEPTH - 1));
    assign status.special    = taken_full || bad_sym;
    assign status.p_zero     = (p_reg == sae_pkg::NO_STATE);
    assign status.edge_zero  = (tr_rdata == sae_pkg::NO_STATE);
    assign status.len_match  = (len_rdata == want_reg);
    assign status.copy_done  = (cnt_reg == sae_pkg::CNT_W'(sae_pkg::ALPHABET_SIZE));
    assign status.edge_is_q  = (tr_rdata == q_reg);
    assign status.out_free   = out_free;

    assign tr_waddr = (cmd.op == sae_pkg::OP_CLEAR) ? clr_reg : sae_pkg::trans_addr(tr_ws, tr_wc);
    assign tr_raddr = sae_pkg::trans_addr(tr_rs, tr_rc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= sae_pkg::ROOT_STATE;
            last_link_reg <= sae_pkg::NO_STATE;
            last_len_reg  <= '0;
            used_reg      <= sae_pkg::ROOT_STATE;
            taken_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_reg      <= last_next;
            last_link_reg <= last_link_next;
            last_len_reg  <= last_len_next;
            used_reg      <= used_next;
            taken_reg     <= taken_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clone_reg   <= clone_next;
        ovf_reg     <= ovf_next;
        cnt_reg     <= cnt_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        np_reg      <= np_next;
        nq_reg      <= nq_next;
        want_reg    <= want_next;
        c_reg       <= c_next;
        o_state_reg <= o_state_next;
        o_link_reg  <= o_link_next;
        o_len_reg   <= o_len_next;
        o_count_reg <= o_count_next;
        o_clone_reg <= o_clone_next;
        o_ovf_reg   <= o_ovf_next;
    end

    always_comb
    begin
        last_next      = last_reg;
        last_link_next = last_link_reg;
        last_len_next  = last_len_reg;
        used_next      = used_reg;
        taken_next     = taken_reg;
        clone_next     = clone_reg;
        ovf_next       = ovf_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        np_next        = np_reg;
        nq_next        = nq_reg;
        want_next      = want_reg;
        c_next         = c_reg;

        out_valid_next = out_valid_reg && out_stall;
        o_state_next   = o_state_reg;
        o_link_next    = o_link_reg;
        o_len_next     = o_len_reg;
        o_count_next   = o_count_reg;
        o_clone_next   = o_clone_reg;
        o_ovf_next     = o_ovf_reg;

        tr_we      = 1'b0;
        tr_ws      = p_reg;
        tr_wc      = c_reg;
        tr_wdata   = np_reg;
        tr_rs      = p_reg;
        tr_rc      = c_reg;
        len_we     = 1'b0;
        len_waddr  = sae_pkg::ROOT_STATE;
        len_wdata  = '0;
        len_raddr  = p_reg;
        link_we    = 1'b0;
        link_waddr = sae_pkg::ROOT_STATE;
        link_wdata = '0;
        link_raddr = p_reg;

        unique case (cmd.op)
            sae_pkg::OP_CLEAR:
            begin
                tr_we    = 1'b1;
                tr_wdata = '0;
                len_we   = 1'b1;
                link_we  = 1'b1;
                clr_next = clr_reg + AW'(1);
            end
            sae_pkg::OP_IDLE:
            begin
                if (cmd.accept)
                begin
                    c_next     = symbol;
                    clone_next = 1'b0;
                    ovf_next   = taken_full;
                    if (!(taken_full || bad_sym))
                    begin
                        taken_next    = taken_reg + sae_pkg::TAKEN_W'(1);
                        np_next       = used_reg + SW'(1);
                        used_next     = used_reg + SW'(1);
                        last_next     = used_reg + SW'(1);
                        p_next        = last_reg;
                        last_len_next = last_len_reg + SW'(1);
                        len_we        = 1'b1;
                        len_waddr     = used_reg + SW'(1);
                        len_wdata     = last_len_reg + SW'(1);
                    end
                end
            end
            sae_pkg::OP_W1_RD:
            begin
                if (p_reg == sae_pkg::NO_STATE)
                begin
                    last_link_next = sae_pkg::ROOT_STATE;
                end
            end
            sae_pkg::OP_W1_CHK:
            begin
                if (tr_rdata == sae_pkg::NO_STATE)
                begin
                    tr_we  = 1'b1;
                    p_next = link_rdata;
                end
                else
                begin
                    q_next    = tr_rdata;
                    want_next = len_rdata + SW'(1);
                    len_raddr = tr_rdata;
                end
            end
            sae_pkg::OP_Q_CHK:
            begin
                link_raddr = q_reg;
                if (len_rdata == want_reg)
                begin
                    last_link_next = q_reg;
                end
                else
                begin
                    nq_next        = used_reg + SW'(1);
                    used_next      = used_reg + SW'(1);
                    last_link_next = used_reg + SW'(1);
                    clone_next     = 1'b1;
                    len_we         = 1'b1;
                    len_waddr      = used_reg + SW'(1);
                    len_wdata      = want_reg;
                    cnt_next       = '0;
                end
            end
            sae_pkg::OP_COPY:
            begin
                tr_rs    = q_reg;
                tr_rc    = sae_pkg::SYM_W'(cnt_reg);
                tr_ws    = nq_reg;
                tr_wc    = sae_pkg::SYM_W'(cnt_reg - sae_pkg::CNT_W'(1));
                tr_wdata = tr_rdata;
                tr_we    = (cnt_reg != '0);
                cnt_next = cnt_reg + sae_pkg::CNT_W'(1);
                // clone inherits the link of q, then q links to the clone
                if (cnt_reg == '0)
                begin
                    link_we    = 1'b1;
                    link_waddr = nq_reg;
                    link_wdata = link_rdata;
                end
                else if (cnt_reg == sae_pkg::CNT_W'(1))
                begin
                    link_we    = 1'b1;
                    link_waddr = q_reg;
                    link_wdata = nq_reg;
                end
            end
            sae_pkg::OP_W2_RD:
            begin
            end
            sae_pkg::OP_W2_CHK:
            begin
                if (tr_rdata == q_reg)
                begin
                    tr_we    = 1'b1;
                    tr_wdata = nq_reg;
                    p_next   = link_rdata;
                end
            end
            sae_pkg::OP_FIN:
            begin
                link_we    = 1'b1;
                link_waddr = last_reg;
                link_wdata = last_link_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_state_next   = last_reg;
                    o_link_next    = last_link_reg;
                    o_len_next     = last_len_reg;
                    o_count_next   = used_reg;
                    o_clone_next   = clone_reg;
                    o_ovf_next     = ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    sae_ram #(.WIDTH(SW), .DEPTH(sae_pkg::TRANS_DEPTH)) u_trans (
        .clk   (clk),
        .we    (tr_we),
        .waddr (tr_waddr),
        .wdata (tr_wdata),
        .raddr (tr_raddr),
        .rdata (tr_rdata)
    );

    sae_ram #(.WIDTH(SW), .DEPTH(sae_pkg::NSTATES)) u_len (
        .clk   (clk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (len_raddr),
        .rdata (len_rdata)
    );

    sae_ram #(.WIDTH(SW), .DEPTH(sae_pkg::NSTATES)) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign new_state     = o_state_reg;
    assign suffix_link   = o_link_reg;
    assign prefix_length = o_len_reg;
    assign state_count   = o_count_reg;
    assign cloned        = o_clone_reg;
    assign overflow      = o_ovf_reg;

endmodule
`default_nettype wire

// ----- sv/suffix_automaton_extend.sv -----
// channel   | direction | handshake           | payload
// request   | in        | in_valid / in_stall | symbol
// result    | out       | out_valid/out_stall | new_state, suffix_link, prefix_length,
//           |           |                     | state_count, cloned, overflow
//
// one request at a time: each step of the first suffix-link walk reads, then checks;
// the length check, a clone copy of every transition and the redirect walk follow,
// then the result is registered; refused symbols go straight to the result state
// walk steps are bound by the single read port of the transition memory
// after reset a clearing pass zeroes the transition memory,
// during which in_stall is high
// a result waiting on out_stall does not block the next request's walk
`default_nettype none
module suffix_automaton_extend (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [sae_pkg::SYM_W-1:0]           symbol,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [sae_pkg::STATE_W-1:0]         new_state,
    output logic      [sae_pkg::STATE_W-1:0]         suffix_link,
    output logic      [sae_pkg::STATE_W-1:0]         prefix_length,
    output logic      [sae_pkg::STATE_W-1:0]         state_count,
    output logic                                     cloned,
    output logic                                     overflow
);

    // command from the sequencer, status back from the datapath
    sae_pkg::cmd_t    cmd;
    sae_pkg::status_t status;

    sae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // transition, length and link memories plus walk registers
    sae_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .symbol        (symbol),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .new_state     (new_state),
        .suffix_link   (suffix_link),
        .prefix_length (prefix_length),
        .state_count   (state_count),
        .cloned        (cloned),
        .overflow      (overflow)
    );

endmodule
`default_nettype wire
